/* rtl/hpid_pkg.sv */
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, constants and beat types for the multichannel heater PID core.
// ----------------------------------------------------------------------------
package hpid_pkg;

    // channel layout and fixed-point format
    localparam int CHANNELS           = 5;
    localparam int SECOND_GROUP_START = 3;
    localparam int GAIN_FRAC_W        = 12;

    // field widths
    localparam int CH_W       = 3;
    localparam int TEMP_W     = 12;
    localparam int DUTY_W     = 10;
    localparam int GAIN_W     = 8 + GAIN_FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // internal arithmetic widths
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = 5;
    localparam int ERR_W    = TEMP_W + 1;
    localparam int D1_W     = ERR_W + 1;
    localparam int D2_W     = ERR_W + 3;
    localparam int ACC_W    = 12 + GAIN_FRAC_W;
    localparam int PROD_W   = GAIN_W + 1 + D2_W;
    localparam int SUM_W    = PROD_W + 2;

    // duty levels in whole units
    localparam int FULL_DUTY = 999;
    localparam int HALF_DUTY = 500;
    localparam int HIGH_CAP  = 400;
    localparam int LOW_CAP   = 150;
    localparam int NEG_LIMIT = 1023;

    // register defaults
    localparam logic [GAIN_W-1:0] KP_RESET        = GAIN_W'(8192);
    localparam logic [GAIN_W-1:0] KI_RESET        = GAIN_W'(61440);
    localparam logic [GAIN_W-1:0] KD_FIRST_RESET  = GAIN_W'(819);
    localparam logic [GAIN_W-1:0] KD_SECOND_RESET = GAIN_W'(41);
    localparam logic [TEMP_W-1:0] FULL_ERR_RESET  = TEMP_W'(120);
    localparam logic [TEMP_W-1:0] HALF_ERR_RESET  = TEMP_W'(50);
    localparam logic [TEMP_W-1:0] HIGH_TGT_RESET  = TEMP_W'(700);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_KI        = 3'd1,
        CFG_KD_FIRST  = 3'd2,
        CFG_KD_SECOND = 3'd3,
        CFG_FULL_ERR  = 3'd4,
        CFG_HALF_ERR  = 3'd5,
        CFG_HIGH_TGT  = 3'd6
    } t_cfg_idx;

    // per-item update kind
    typedef enum logic [2:0] {
        MODE_PID,
        MODE_FULL,
        MODE_HALF,
        MODE_ZERO,
        MODE_SKIP
    } t_mode;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd_first;
        logic [GAIN_W-1:0] kd_second;
        logic [TEMP_W-1:0] full_power_error;
        logic [TEMP_W-1:0] half_power_error;
        logic [TEMP_W-1:0] high_setpoint;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [TEMP_W-1:0] setpoint;
        logic [TEMP_W-1:0] measured_temp;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic [DUTY_W-1:0] duty;
    } t_out;

    // error stage to accumulator stage
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        t_mode                    mode;
        logic                     cap_high;
        logic signed [PROD_W-1:0] p_kp;
        logic signed [PROD_W-1:0] p_ki;
        logic signed [PROD_W-1:0] p_kd;
    } t_prod;

endpackage

/* rtl/hpid_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hpid_cfg_regs
// Gain and threshold registers behind the plain write port.
// ----------------------------------------------------------------------------
module hpid_cfg_regs
    import hpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp               <= KP_RESET;
            r_cfg.ki               <= KI_RESET;
            r_cfg.kd_first         <= KD_FIRST_RESET;
            r_cfg.kd_second        <= KD_SECOND_RESET;
            r_cfg.full_power_error <= FULL_ERR_RESET;
            r_cfg.half_power_error <= HALF_ERR_RESET;
            r_cfg.high_setpoint    <= HIGH_TGT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:        r_cfg.kp               <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:        r_cfg.ki               <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_FIRST:  r_cfg.kd_first         <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_SECOND: r_cfg.kd_second        <= i_cfg_data[GAIN_W-1:0];
                CFG_FULL_ERR:  r_cfg.full_power_error <= i_cfg_data[TEMP_W-1:0];
                CFG_HALF_ERR:  r_cfg.half_power_error <= i_cfg_data[TEMP_W-1:0];
                CFG_HIGH_TGT:  r_cfg.high_setpoint    <= i_cfg_data[TEMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/hpid_err_stage.sv */
// ----------------------------------------------------------------------------
// hpid_err_stage
// Input register, error history per channel, band decision and gain products.
// ----------------------------------------------------------------------------
module hpid_err_stage
    import hpid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in_data,
    output logic  o_prod_valid,
    input  logic  i_prod_ready,
    output t_prod o_prod
);

    localparam logic [CMP_W-1:0] CH_LIMIT     = CMP_W'(CHANNELS);
    localparam logic [CMP_W-1:0] GROUP2_START = CMP_W'(SECOND_GROUP_START);

    t_in                     r_in;
    logic                    r_in_vld;
    t_prod                   r_prod;
    logic                    r_prod_vld;
    logic signed [ERR_W-1:0] r_prev_err [CHANNELS];
    logic signed [ERR_W-1:0] r_old_err  [CHANNELS];

    t_prod                   n_prod;
    logic                    in_ready;
    logic                    fire;
    logic                    in_range;
    logic [CH_IDX_W-1:0]     ch_idx;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] err1;
    logic signed [ERR_W-1:0] err2;
    logic signed [ERR_W-1:0] full_thr;
    logic signed [ERR_W-1:0] half_thr;
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
    logic [GAIN_W-1:0]       kd;

    assign in_ready   = !r_in_vld || fire;
    assign fire       = r_in_vld && (!r_prod_vld || i_prod_ready);
    assign o_in_stall = !in_ready;

    // error, band and products for the item in the input register
    always_comb begin
        in_range = {{(CMP_W - CH_W){1'b0}}, r_in.channel} < CH_LIMIT;
        ch_idx   = r_in.channel[CH_IDX_W-1:0];
        err      = $signed({1'b0, r_in.setpoint}) - $signed({1'b0, r_in.measured_temp});
        err1     = in_range ? r_prev_err[ch_idx] : '0;
        err2     = in_range ? r_old_err[ch_idx]  : '0;
        full_thr = $signed({1'b0, i_cfg.full_power_error});
        half_thr = $signed({1'b0, i_cfg.half_power_error});
        d1       = D1_W'(err) - D1_W'(err1);
        d2       = D2_W'(err) - (D2_W'(err1) <<< 1) + D2_W'(err2);
        kd       = ({{(CMP_W - CH_W){1'b0}}, r_in.channel} < GROUP2_START)
                   ? i_cfg.kd_first : i_cfg.kd_second;

        n_prod.channel  = r_in.channel;
        n_prod.cap_high = r_in.setpoint > i_cfg.high_setpoint;
        priority if (!in_range) begin
            n_prod.mode = MODE_SKIP;
        end else if (err >= full_thr) begin
            n_prod.mode = MODE_FULL;
        end else if (err >= half_thr) begin
            n_prod.mode = MODE_HALF;
        end else if (err < $signed(ERR_W'(0))) begin
            n_prod.mode = MODE_ZERO;
        end else begin
            n_prod.mode = MODE_PID;
        end
        n_prod.p_kp = PROD_W'($signed({1'b0, i_cfg.kp})) * PROD_W'(d1);
        n_prod.p_ki = PROD_W'($signed({1'b0, i_cfg.ki})) * PROD_W'(err);
        n_prod.p_kd = PROD_W'($signed({1'b0, kd}))       * PROD_W'(d2);
    end

    // valids and error history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_prev_err[i] <= '0;
                r_old_err[i]  <= '0;
            end
        end else begin
            if (in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (!r_prod_vld || i_prod_ready) begin
                r_prod_vld <= r_in_vld;
            end
            if (fire && in_range) begin
                r_prev_err[ch_idx] <= err;
                r_old_err[ch_idx]  <= err1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod_valid = r_prod_vld;
    assign o_prod       = r_prod;

endmodule

/* rtl/hpid_acc_stage.sv */
// ----------------------------------------------------------------------------
// hpid_acc_stage
// Duty accumulator per channel, clamping and the result register.
// ----------------------------------------------------------------------------
module hpid_acc_stage
    import hpid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_prod_valid,
    output logic  o_prod_ready,
    input  t_prod i_prod,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out_data
);

    localparam logic signed [ACC_W-1:0] FULL_ACC = ACC_W'(FULL_DUTY * (1 << GAIN_FRAC_W));
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(HALF_DUTY * (1 << GAIN_FRAC_W));
    localparam logic signed [SUM_W-1:0] CAP_HI   = SUM_W'(HIGH_CAP * (1 << GAIN_FRAC_W));
    localparam logic signed [SUM_W-1:0] CAP_LO   = SUM_W'(LOW_CAP * (1 << GAIN_FRAC_W));
    localparam logic signed [SUM_W-1:0] NEG_ACC  = SUM_W'(-(NEG_LIMIT * (1 << GAIN_FRAC_W)));

    logic signed [ACC_W-1:0] r_acc [CHANNELS];
    t_out                    r_out;
    logic                    r_out_vld;

    t_out                    n_out;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] acc_old;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] cap;
    logic [CH_IDX_W-1:0]     ch_idx;
    logic                    ready;
    logic                    fire;

    assign ready = !r_out_vld || !i_out_stall;
    assign fire  = i_prod_valid && ready;

    // accumulate, clamp and form the duty
    always_comb begin
        ch_idx  = i_prod.channel[CH_IDX_W-1:0];
        acc_old = (i_prod.mode == MODE_SKIP) ? '0 : r_acc[ch_idx];
        sum     = SUM_W'(acc_old) + i_prod.p_kp + i_prod.p_ki + i_prod.p_kd;
        cap     = i_prod.cap_high ? CAP_HI : CAP_LO;
        unique case (i_prod.mode)
            MODE_FULL: n_acc = FULL_ACC;
            MODE_HALF: n_acc = HALF_ACC;
            MODE_ZERO: n_acc = '0;
            MODE_PID: begin
                priority if (sum >= cap) begin
                    n_acc = cap[ACC_W-1:0];
                end else if (sum < NEG_ACC) begin
                    n_acc = NEG_ACC[ACC_W-1:0];
                end else begin
                    n_acc = sum[ACC_W-1:0];
                end
            end
            MODE_SKIP: n_acc = '0;
            default:   n_acc = '0;
        endcase
        n_out.out_channel = i_prod.channel;
        n_out.duty        = n_acc[ACC_W-1] ? '0 : n_acc[GAIN_FRAC_W +: DUTY_W];
    end

    // result valid and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (ready) begin
                r_out_vld <= i_prod_valid;
            end
            if (fire && (i_prod.mode != MODE_SKIP)) begin
                r_acc[ch_idx] <= n_acc;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_prod_ready = ready;
    assign o_out_valid  = r_out_vld;
    assign o_out_data   = r_out;

endmodule

/* rtl/multichannel_incremental_pid_heater_core.sv */
// ----------------------------------------------------------------------------
// multichannel_incremental_pid_heater_core
// Five-channel velocity-form PID heater duty controller.
// ----------------------------------------------------------------------------
// Each input beat names a channel with a target and a measured temperature and
// yields exactly one result beat with that channel's new duty (0..999). Large
// errors force full or half duty, negative errors force zero, otherwise the
// channel accumulator adds the incremental PID term and is capped at 400 or
// 150. The core takes one beat per clock while the output is not stalled and
// returns results in order; an accepted input is loaded into the input
// register, then the register after the three gain multipliers, then the
// result register. Error history is updated as an item leaves the input
// register and the accumulator as it enters the result register, so
// consecutive beats for the same channel need no gaps. Write the gain and
// threshold registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module multichannel_incremental_pid_heater_core
    import hpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    t_cfg  cfg;
    t_prod prod;
    logic  prod_valid;
    logic  prod_ready;

    // gain and threshold registers
    hpid_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // error history and products
    hpid_err_stage u_err (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_prod_valid (prod_valid),
        .i_prod_ready (prod_ready),
        .o_prod       (prod)
    );

    // accumulators and result register
    hpid_acc_stage u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prod_valid (prod_valid),
        .o_prod_ready (prod_ready),
        .i_prod       (prod),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

/* tb/sv/heater_duty_watch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_duty_watch
// Watches the heater PID core's ports, predicts every duty beat and compares.
// ----------------------------------------------------------------------------
// Follows register writes to keep its own copy of the gains and thresholds.
// Keeps per-channel accumulator and error history, works out the duty for
// each accepted input beat and queues it. Each accepted result beat is
// checked field by field against the oldest queued duty. Exposes the number
// of duties still outstanding, the number compared and the failure count.
// ----------------------------------------------------------------------------
module heater_duty_watch
    import hpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out_data,
    output int                    o_pending,
    output int                    o_compared,
    output int                    o_fail_count
);

    // shadow of the gain and threshold registers
    t_cfg gains;

    // per-channel controller state
    logic signed [ACC_W-1:0] acc_q     [CHANNELS];
    logic signed [ERR_W-1:0] prev_err  [CHANNELS];
    logic signed [ERR_W-1:0] older_err [CHANNELS];

    // duties waiting for their result beat, oldest first
    t_out duty_q [$];
    int   compared;
    int   fails;

    // one controller step: new duty for a reading, updating channel state
    function automatic t_out next_duty(input t_in b);
        t_out   r;
        int     e;
        int     e1;
        int     e2;
        longint a;
        longint kd;
        longint cap;
        r.out_channel = b.channel;
        r.duty        = '0;
        // readings for channels that do not exist leave all state alone
        if (b.channel >= CHANNELS) return r;
        e  = int'(b.setpoint) - int'(b.measured_temp);
        e1 = prev_err[b.channel];
        e2 = older_err[b.channel];
        a  = acc_q[b.channel];
        // full power is tested first, so a half threshold above it never fires
        if (e >= int'(gains.full_power_error)) begin
            a = longint'(FULL_DUTY) <<< GAIN_FRAC_W;
        end else if (e >= int'(gains.half_power_error)) begin
            a = longint'(HALF_DUTY) <<< GAIN_FRAC_W;
        end else if (e < 0) begin
            a = 0;
        end else begin
            kd = (b.channel < SECOND_GROUP_START) ? longint'(gains.kd_first)
                                                  : longint'(gains.kd_second);
            a += longint'(gains.kp) * longint'(e - e1)
               + longint'(gains.ki) * longint'(e)
               + kd * longint'(e - 2 * e1 + e2);
            cap = (b.setpoint > gains.high_setpoint) ? longint'(HIGH_CAP)
                                                     : longint'(LOW_CAP);
            cap = cap <<< GAIN_FRAC_W;
            if (a >= cap) a = cap;
            // negative side saturates and reads back as zero duty
            if (a < -(longint'(NEG_LIMIT) <<< GAIN_FRAC_W))
                a = -(longint'(NEG_LIMIT) <<< GAIN_FRAC_W);
        end
        acc_q[b.channel]     = ACC_W'(a);
        older_err[b.channel] = prev_err[b.channel];
        prev_err[b.channel]  = ERR_W'(e);
        if (a > 0) r.duty = DUTY_W'(a >>> GAIN_FRAC_W);
        return r;
    endfunction

    // follow writes, check results, queue predictions
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (!i_rst_n) begin
            gains = '{KP_RESET, KI_RESET, KD_FIRST_RESET, KD_SECOND_RESET,
                      FULL_ERR_RESET, HALF_ERR_RESET, HIGH_TGT_RESET};
            for (int c = 0; c < CHANNELS; c++) begin
                acc_q[c]     = '0;
                prev_err[c]  = '0;
                older_err[c] = '0;
            end
            duty_q.delete();
            compared = 0;
            fails    = 0;
        end else begin
            // register writes, 12-bit registers keep only their low bits
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:        gains.kp               = i_cfg_data;
                    CFG_KI:        gains.ki               = i_cfg_data;
                    CFG_KD_FIRST:  gains.kd_first         = i_cfg_data;
                    CFG_KD_SECOND: gains.kd_second        = i_cfg_data;
                    CFG_FULL_ERR:  gains.full_power_error = i_cfg_data[TEMP_W-1:0];
                    CFG_HALF_ERR:  gains.half_power_error = i_cfg_data[TEMP_W-1:0];
                    CFG_HIGH_TGT:  gains.high_setpoint    = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (duty_q.size() == 0) begin
                    $display("%0t: unexpected result beat, channel %0d duty %0d",
                             $time, got.out_channel, got.duty);
                    fails++;
                end else begin
                    want = duty_q.pop_front();
                    compared++;
                    if (got.out_channel !== want.out_channel) begin
                        $display("%0t: out_channel mismatch, expected %0d actual %0d",
                                 $time, want.out_channel, got.out_channel);
                        fails++;
                    end
                    if (got.duty !== want.duty) begin
                        $display("%0t: duty mismatch on channel %0d, expected %0d actual %0d",
                                 $time, want.out_channel, want.duty, got.duty);
                        fails++;
                    end
                end
            end
            // input beat: predict its duty
            if (i_in_valid && !i_in_stall) duty_q.push_back(next_duty(i_in_data));
        end
        o_pending    <= duty_q.size();
        o_compared   <= compared;
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the multichannel heater PID core.
// ----------------------------------------------------------------------------
// Runs a short directed set of readings under the reset gains, then random
// readings under several register settings, extremes included, with three
// idling patterns on both channels, one long output hold-off and a drain
// after each block. Predicting and checking is done by heater_duty_watch.
// ----------------------------------------------------------------------------
module testbench;
    import hpid_pkg::*;

    localparam int TEMP_MAX       = (1 << TEMP_W) - 1;
    localparam int CH_MAX         = (1 << CH_W) - 1;
    localparam int READINGS_BLOCK = 63;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTING_COUNT  = 5;

    // index past the register list, writes to it are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_KP;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in                   in_data    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out                  out_data;

    int   pending;
    int   compared;
    int   fail_count;

    // idling percentages, output hold-off cycles left
    int   send_gap_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left     = 0;
    int   n_readings    = 0;
    int   n_settings    = 0;

    // register values now in force, used to aim random errors
    t_cfg cur = '{KP_RESET, KI_RESET, KD_FIRST_RESET, KD_SECOND_RESET,
                  FULL_ERR_RESET, HALF_ERR_RESET, HIGH_TGT_RESET};
    t_cfg settings [SETTING_COUNT];

    multichannel_incremental_pid_heater_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    heater_duty_watch duty_watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // output side: random stall, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // watchdog on cycles where no beat moves
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", quiet);
        $display("CHECKS FAILED");
        $finish;
    end

    // idling pattern: sender 24 / receiver 80, then swapped, then none
    task automatic set_idling(input int pattern);
        case (pattern)
            0: begin
                send_gap_pct   = 24;
                recv_stall_pct = 80;
            end
            1: begin
                send_gap_pct   = 80;
                recv_stall_pct = 24;
            end
            default: begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // one input beat, with random gaps ahead of it
    task automatic send_reading(input t_in b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        n_readings++;
    endtask

    // stop sending and wait for every outstanding duty
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write every register, junk in the unused high bits of 12-bit ones
    task automatic apply_settings(input t_cfg s);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_KP;
        cfg_data <= s.kp;
        @(posedge clk);
        cfg_idx  <= CFG_KI;
        cfg_data <= s.ki;
        @(posedge clk);
        cfg_idx  <= CFG_KD_FIRST;
        cfg_data <= s.kd_first;
        @(posedge clk);
        cfg_idx  <= CFG_KD_SECOND;
        cfg_data <= s.kd_second;
        @(posedge clk);
        cfg_idx  <= CFG_FULL_ERR;
        cfg_data <= {junk[CFG_DATA_W-1:TEMP_W], s.full_power_error};
        @(posedge clk);
        cfg_idx  <= CFG_HALF_ERR;
        cfg_data <= {junk[CFG_DATA_W-1:TEMP_W], s.half_power_error};
        @(posedge clk);
        cfg_idx  <= CFG_HIGH_TGT;
        cfg_data <= {junk[CFG_DATA_W-1:TEMP_W], s.high_setpoint};
        @(posedge clk);
        cfg_idx  <= CFG_UNUSED;
        cfg_data <= junk;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur = s;
        n_settings++;
    endtask

    // random reading, mostly aimed at the PID band of the current thresholds
    function automatic t_in random_reading();
        t_in r;
        int  tgt;
        int  meas;
        int  band;
        int  k;
        if ($urandom_range(0, 9) != 0)
            r.channel = CH_W'($urandom_range(0, CHANNELS - 1));
        else
            r.channel = CH_W'($urandom_range(CHANNELS, CH_MAX));
        // targets cluster around the cap threshold a third of the time
        if ($urandom_range(0, 2) == 0) begin
            tgt = int'(cur.high_setpoint) + int'($urandom_range(0, 8)) - 4;
            if (tgt < 0) tgt = 0;
            if (tgt > TEMP_MAX) tgt = TEMP_MAX;
        end else begin
            tgt = int'($urandom_range(0, TEMP_MAX));
        end
        band = (cur.half_power_error < cur.full_power_error) ?
               int'(cur.half_power_error) : int'(cur.full_power_error);
        k = int'($urandom_range(0, 99));
        if (k < 65) begin
            meas = tgt - int'($urandom_range(0, band + 1));
            if (meas < 0) meas = 0;
        end else if (k < 78) begin
            meas = int'($urandom_range(0, tgt));
        end else if (k < 92) begin
            meas = int'($urandom_range(tgt, TEMP_MAX));
        end else begin
            meas = int'($urandom_range(0, TEMP_MAX));
        end
        r.setpoint      = TEMP_W'(tgt);
        r.measured_temp = TEMP_W'(meas);
        return r;
    endfunction

    // main sequence
    initial begin
        settings[0] = '{'1, '1, '1, '1, '1, '1, '0};
        settings[1] = '{'0, '0, '0, '0, '1, '0, '1};
        settings[2] = '{20'd4096, 20'd2048, 20'd8192, 20'd100, 12'd30, 12'd80, 12'd2000};
        settings[3] = '{'1, 20'd0, '1, 20'd0, 12'd200, 12'd100, 12'd1000};
        settings[4] = '{KP_RESET, KI_RESET, KD_FIRST_RESET, KD_SECOND_RESET,
                        FULL_ERR_RESET, HALF_ERR_RESET, HIGH_TGT_RESET};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // directed readings under reset gains
        send_reading(t_in'{3'd0, 12'd100, 12'd100});
        send_reading(t_in'{3'd0, 12'd130, 12'd100});
        send_reading(t_in'{3'd0, 12'd130, 12'd100});
        send_reading(t_in'{3'd1, 12'd620, 12'd500});
        send_reading(t_in'{3'd1, 12'd619, 12'd500});
        send_reading(t_in'{3'd1, 12'd550, 12'd500});
        send_reading(t_in'{3'd1, 12'd549, 12'd500});
        send_reading(t_in'{3'd2, 12'd800, 12'd790});
        send_reading(t_in'{3'd2, 12'd800, 12'd790});
        send_reading(t_in'{3'd2, 12'd800, 12'd790});
        send_reading(t_in'{3'd2, 12'd700, 12'd690});
        send_reading(t_in'{3'd3, 12'd99, 12'd100});
        send_reading(t_in'{3'd3, 12'd0, 12'd4095});
        send_reading(t_in'{3'd3, 12'd40, 12'd10});
        send_reading(t_in'{3'd4, 12'd4095, 12'd0});
        send_reading(t_in'{3'd4, 12'd900, 12'd880});
        send_reading(t_in'{3'd4, 12'd900, 12'd899});
        send_reading(t_in'{3'd4, 12'd900, 12'd900});
        send_reading(t_in'{3'd5, 12'd300, 12'd200});
        send_reading(t_in'{3'd6, 12'd4095, 12'd0});
        send_reading(t_in'{3'd7, 12'd0, 12'd4095});
        send_reading(t_in'{3'd0, 12'd4095, 12'd4095});
        send_reading(t_in'{3'd0, 12'd4095, 12'd4090});
        wait_for_results();

        // random readings, each setting under every idling pattern
        for (int p = 0; p < SETTING_COUNT; p++) begin
            apply_settings(settings[p]);
            for (int m = 0; m < 3; m++) begin
                set_idling(m);
                // long output hold-off while the sender keeps offering beats
                if (p == 0 && m == 2) hold_left = LONG_HOLD;
                repeat (READINGS_BLOCK) send_reading(random_reading());
                wait_for_results();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d readings over %0d register settings: forced duties, caps,",
                 n_readings, n_settings);
        $display("saturation, unused channels, idling and back-pressure; %0d beats compared",
                 compared);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
